[sv/assert_macros.svh]
// Assertion macros for the record table RTL.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define DHRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define DHRT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[sv/dhrt_pkg.sv]
// Shared constants, codes, types and the key function of the record table.
// No dependencies.
`timescale 1ns / 1ps

package dhrt_pkg;

	localparam int DHRT_TABLE_DEPTH = 1024;
	localparam int DHRT_NAME_BYTES  = 8;

	localparam int CFG_W    = 11;
	localparam int REQ_W    = 2;
	localparam int RES_W    = 2;
	localparam int ST_W     = 2;
	localparam int NAME_W   = 64;
	localparam int AGE_W    = 8;
	localparam int WEIGHT_W = 16;
	localparam int HEIGHT_W = 16;
	localparam int SLOT_W   = 10;
	localparam int KEY_W    = 11;

	localparam int IN_DATA_W  = NAME_W + AGE_W + WEIGHT_W + HEIGHT_W;
	localparam int OUT_FLD_W  = SLOT_W + AGE_W + WEIGHT_W + HEIGHT_W;
	localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

	localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1024;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

	localparam logic [RES_W-1:0] RES_OK   = 2'd0;
	localparam logic [RES_W-1:0] RES_MISS = 2'd1;
	localparam logic [RES_W-1:0] RES_FULL = 2'd2;

	localparam logic [ST_W-1:0] SLOT_EMPTY = 2'd0;
	localparam logic [ST_W-1:0] SLOT_OCC   = 2'd1;
	localparam logic [ST_W-1:0] SLOT_TOMB  = 2'd2;

	typedef struct packed {
		logic [ST_W-1:0]     state;
		logic [NAME_W-1:0]   name;
		logic [AGE_W-1:0]    age;
		logic [WEIGHT_W-1:0] weight;
		logic [HEIGHT_W-1:0] height;
	} dhrt_entry_t;

	typedef struct packed {
		logic             clr_step;
		logic             load;
		logic             mod_step;
		logic             probe_init;
		logic             rd;
		logic             next;
		logic             wr_ins;
		logic             wr_tomb;
		logic             fin;
		logic [RES_W-1:0] res_code;
		logic             ret_rec;
		logic             out_load;
	} dhrt_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_done;
		logic occ;
		logic empty;
		logic match;
		logic last;
	} dhrt_stat_t;

	function automatic logic [KEY_W-1:0] name_key(input logic [NAME_W-1:0] nm);
		logic [KEY_W-1:0] k;
		k = '0;
		for (int b = 0; b < NAME_W / 8; b++) begin
			k = k + KEY_W'(nm[8*b +: 8]);
		end
		return k;
	endfunction

endpackage

[sv/dhrt_ctrl.sv]
// Controller of the record table: clearing pass, key reduction, probe loop, result hand-off.
// Depends on dhrt_pkg; drives the datapath through dhrt_cmd_t, reads dhrt_stat_t.
`timescale 1ns / 1ps

module dhrt_ctrl import dhrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [REQ_W-1:0] req_type,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  dhrt_stat_t       st,
	output dhrt_cmd_t        cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_RD,
		S_CHK,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [REQ_W-1:0] req_q;
	logic             m_tvalid_q;
	logic             req_ok;
	logic             chk_hit;
	logic             chk_end;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign req_ok   = req_type inside {REQ_INSERT, REQ_SEARCH, REQ_REMOVE};

	always_comb begin
		if (req_q == REQ_INSERT) begin
			chk_hit = !st.occ;
		end else begin
			chk_hit = st.occ && st.match;
		end
		chk_end = st.last || ((req_q != REQ_INSERT) && st.empty);
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (!req_ok) begin
						cmd.fin      = 1'b1;
						cmd.res_code = RES_MISS;
					end
				end
			end
			S_MOD: begin
				if (!st.mod_done) begin
					cmd.mod_step = 1'b1;
				end else begin
					cmd.probe_init = 1'b1;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
			end
			S_CHK: begin
				if (chk_hit) begin
					cmd.fin      = 1'b1;
					cmd.res_code = RES_OK;
					cmd.wr_ins   = (req_q == REQ_INSERT);
					cmd.wr_tomb  = (req_q == REQ_REMOVE);
					cmd.ret_rec  = (req_q == REQ_SEARCH);
				end else if (chk_end) begin
					cmd.fin      = 1'b1;
					cmd.res_code = (req_q == REQ_INSERT) ? RES_FULL : RES_MISS;
				end else begin
					cmd.next = 1'b1;
				end
			end
			S_DONE: begin
				cmd.out_load = !m_tvalid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			req_q      <= REQ_INSERT;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (st.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						req_q   <= req_type;
						state_q <= req_ok ? S_MOD : S_DONE;
					end
				end
				S_MOD: begin
					if (st.mod_done) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (chk_hit || chk_end) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/dhrt_datapath.sv]
// Datapath of the record table: size register, key remainders, probe stepping,
// slot memory and result registers. Depends on dhrt_pkg; commanded by dhrt_ctrl.
`timescale 1ns / 1ps

module dhrt_datapath import dhrt_pkg::*; #(
	parameter int TABLE_DEPTH = DHRT_TABLE_DEPTH,
	parameter int NAME_BYTES  = DHRT_NAME_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic [NAME_W-1:0]   name,
	input  logic [AGE_W-1:0]    age,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic [HEIGHT_W-1:0] height,
	input  dhrt_cmd_t           cmd,
	output dhrt_stat_t          st,
	output logic [RES_W-1:0]    status,
	output logic [SLOT_W-1:0]   slot,
	output logic [AGE_W-1:0]    age_out,
	output logic [WEIGHT_W-1:0] weight_out,
	output logic [HEIGHT_W-1:0] height_out
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int MW    = (IDX_W + 1 < CFG_W) ? IDX_W + 1 : CFG_W;
	localparam int CNT_W = $clog2(KEY_W + 1);
	localparam logic [NAME_W-1:0] NAME_MASK = (NAME_BYTES >= 8) ? {NAME_W{1'b1}} :
		NAME_W'((65'd1 << (8 * NAME_BYTES)) - 65'd1);

	logic [CFG_W-1:0]    table_size_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    clr_q;

	logic [NAME_W-1:0]   name_q;
	logic [AGE_W-1:0]    age_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [KEY_W-1:0]    sh_q;
	logic [MW-1:0]       m_q;
	logic [MW-1:0]       rem1_q;
	logic [MW-1:0]       rem2_q;
	logic [MW-1:0]       j_q;
	logic [MW-1:0]       h2_q;
	logic [MW-1:0]       i_q;

	logic [RES_W-1:0]    res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [AGE_W-1:0]    res_age_q;
	logic [WEIGHT_W-1:0] res_weight_q;
	logic [HEIGHT_W-1:0] res_height_q;
	logic [RES_W-1:0]    out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [AGE_W-1:0]    out_age_q;
	logic [WEIGHT_W-1:0] out_weight_q;
	logic [HEIGHT_W-1:0] out_height_q;

	dhrt_entry_t         mem [TABLE_DEPTH];
	dhrt_entry_t         rd_q;
	dhrt_entry_t         mem_wd;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	logic [IDX_W-1:0]    j_idx;

	logic [MW-1:0]       m_now;
	logic [MW-1:0]       m_less;
	logic [MW:0]         t1;
	logic [MW:0]         t2;
	logic [MW:0]         n1;
	logic [MW:0]         n2;
	logic [MW:0]         psum;
	logic [MW:0]         pnext;

	always_comb begin
		if (table_size_q < CFG_W'(2)) begin
			m_now = MW'(2);
		end else if (32'(table_size_q) > 32'(TABLE_DEPTH)) begin
			m_now = MW'(TABLE_DEPTH);
		end else begin
			m_now = MW'(table_size_q);
		end
	end

	assign m_less = m_q - MW'(1);
	assign t1     = {rem1_q, sh_q[KEY_W-1]};
	assign t2     = {rem2_q, sh_q[KEY_W-1]};
	assign n1     = (t1 >= {1'b0, m_q}) ? t1 - {1'b0, m_q} : t1;
	assign n2     = (t2 >= {1'b0, m_less}) ? t2 - {1'b0, m_less} : t2;
	assign psum   = {1'b0, j_q} + {1'b0, h2_q};
	assign pnext  = (psum >= {1'b0, m_q}) ? psum - {1'b0, m_q} : psum;
	assign j_idx  = IDX_W'(j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
			cnt_q        <= '0;
			clr_q        <= '0;
		end else begin
			if (cfg_we) begin
				table_size_q <= cfg_wdata;
			end
			if (cmd.load) begin
				cnt_q <= CNT_W'(KEY_W);
			end else if (cmd.mod_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			name_q   <= name & NAME_MASK;
			age_q    <= age;
			weight_q <= weight;
			height_q <= height;
			sh_q     <= name_key(name & NAME_MASK);
			m_q      <= m_now;
			rem1_q   <= '0;
			rem2_q   <= '0;
		end else if (cmd.mod_step) begin
			sh_q   <= {sh_q[KEY_W-2:0], 1'b0};
			rem1_q <= n1[MW-1:0];
			rem2_q <= n2[MW-1:0];
		end
		if (cmd.probe_init) begin
			j_q  <= rem1_q;
			h2_q <= rem2_q + MW'(1);
			i_q  <= '0;
		end else if (cmd.next) begin
			j_q <= pnext[MW-1:0];
			i_q <= i_q + MW'(1);
		end
		if (cmd.fin) begin
			res_status_q <= cmd.res_code;
			res_slot_q   <= (cmd.res_code == RES_OK) ? SLOT_W'(j_q) : '0;
			res_age_q    <= cmd.ret_rec ? rd_q.age : '0;
			res_weight_q <= cmd.ret_rec ? rd_q.weight : '0;
			res_height_q <= cmd.ret_rec ? rd_q.height : '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_age_q    <= res_age_q;
			out_weight_q <= res_weight_q;
			out_height_q <= res_height_q;
		end
	end

	always_comb begin
		mem_we = cmd.clr_step || cmd.wr_ins || cmd.wr_tomb;
		mem_wa = cmd.clr_step ? clr_q : j_idx;
		mem_wd = rd_q;
		mem_wd.state = SLOT_TOMB;
		if (cmd.clr_step) begin
			mem_wd = '0;
		end else if (cmd.wr_ins) begin
			mem_wd.state  = SLOT_OCC;
			mem_wd.name   = name_q;
			mem_wd.age    = age_q;
			mem_wd.weight = weight_q;
			mem_wd.height = height_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.rd) begin
			rd_q <= mem[j_idx];
		end
	end

	assign st.clr_last = (clr_q == IDX_W'(TABLE_DEPTH - 1));
	assign st.mod_done = (cnt_q == '0);
	assign st.occ      = (rd_q.state == SLOT_OCC);
	assign st.empty    = (rd_q.state == SLOT_EMPTY);
	assign st.match    = (rd_q.name == name_q);
	assign st.last     = (i_q == m_less);

	assign status     = out_status_q;
	assign slot       = out_slot_q;
	assign age_out    = out_age_q;
	assign weight_out = out_weight_q;
	assign height_out = out_height_q;

endmodule

[sv/double_hash_record_table.sv]
// Top level of the double-hashing record table: stream ports, config port, assertions.
// Depends on dhrt_pkg, dhrt_ctrl, dhrt_datapath and assert_macros.svh.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+---------------------------------------
//  s_*      | in        | s_tvalid/s_tready | tuser req_type; tdata name, age, ...
//  m_*      | out       | m_tvalid/m_tready | tuser status; tdata slot, age_out, ...
//  cfg_*    | in        | cfg_we            | table_size
//
// After reset a clearing pass empties the slot memory, no item accepted. An item makes 1 to m
// probes: the key remainders come from a shared restoring unit, one key bit a cycle; each
// probe is one read of the slot memory. An unknown request type skips key reduction and probes.
// The result waits in the output register; the next item is accepted meanwhile, and its result
// holds until the output register frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module double_hash_record_table import dhrt_pkg::*; #(
	parameter int TABLE_DEPTH = DHRT_TABLE_DEPTH,
	parameter int NAME_BYTES  = DHRT_NAME_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata,   // table_size
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,     // name, age, weight, height
	input  logic [REQ_W-1:0]      s_tuser,     // req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,     // slot, age_out, weight_out, height_out, zeros
	output logic [RES_W-1:0]      m_tuser      // status
);

	dhrt_cmd_t           cmd;
	dhrt_stat_t          st;
	logic [SLOT_W-1:0]   slot;
	logic [AGE_W-1:0]    age_out;
	logic [WEIGHT_W-1:0] weight_out;
	logic [HEIGHT_W-1:0] height_out;

	dhrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	dhrt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.NAME_BYTES  (NAME_BYTES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.name       (s_tdata[NAME_W-1:0]),
		.age        (s_tdata[NAME_W +: AGE_W]),
		.weight     (s_tdata[NAME_W+AGE_W +: WEIGHT_W]),
		.height     (s_tdata[NAME_W+AGE_W+WEIGHT_W +: HEIGHT_W]),
		.cmd        (cmd),
		.st         (st),
		.status     (m_tuser),
		.slot       (slot),
		.age_out    (age_out),
		.weight_out (weight_out),
		.height_out (height_out)
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, height_out, weight_out, age_out, slot};

	`DHRT_ASSERT(a_one_writer, $onehot0({cmd.clr_step, cmd.wr_ins, cmd.wr_tomb}), "two memory writers")
	`DHRT_ASSERT(a_busy_after_load, cmd.load |=> !s_tready, "ready right after a load")
	`DHRT_NEVER(a_out_overwrite, cmd.out_load && m_tvalid && !m_tready, "result overwritten")
	`DHRT_NEVER(a_write_while_idle, s_tready && (cmd.wr_ins || cmd.wr_tomb), "write while idle")

endmodule
